// ===== design/ascii_frame_deframer_checksum_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ASCII frame deframer
// Same-cycle and next-cycle implication checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef ASCII_FRAME_DEFRAMER_CHECKSUM_CORE_ASSERT_SVH
`define ASCII_FRAME_DEFRAMER_CHECKSUM_CORE_ASSERT_SVH

// cons must hold in the same cycle as ante
`define AFD_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define AFD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/afd_pkg.sv =====
// ----------------------------------------------------------------------------
// afd_pkg
// Types and constants shared by the ASCII frame deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package afd_pkg;

    // frame layout, in digits
    localparam int TYPE_DIGITS   = 1;
    localparam int IDENT_DIGITS  = 5;
    localparam int LENGTH_DIGITS = 3;
    localparam int CHECK_DIGITS  = 3;

    localparam int CHECK_MODULUS = 666;

    localparam int TYPE_W  = 4;
    localparam int IDENT_W = 17;
    localparam int LEN_W   = 10;
    localparam int CHK_W   = 10;
    localparam int VERD_W  = 3;

    localparam int TDATA_W = 64;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic               result_kind;
        logic [7:0]         payload_byte;
        logic               payload_last;
        logic [TYPE_W-1:0]  message_type;
        logic [IDENT_W-1:0] message_ident;
        logic [LEN_W-1:0]   payload_length;
        logic [CHK_W-1:0]   received_check;
        logic [CHK_W-1:0]   computed_check;
        logic [VERD_W-1:0]  verdict;
    } afd_result_t;

endpackage

`default_nettype wire

// ===== design/afd_parser.sv =====
// ----------------------------------------------------------------------------
// afd_parser
// Frame parse state and the per-beat update: decimal fields, payload pass
// through, mod-666 running checksum and the end-of-frame summary.
// ----------------------------------------------------------------------------
`default_nettype none

module afd_parser (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic [7:0]          byte_in,
    input  wire logic                frame_start,
    output logic                     res_vld,
    output afd_pkg::afd_result_t     res
);
    import afd_pkg::*;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_TYPE    = 3'd1;
    localparam logic [2:0] PH_IDENT   = 3'd2;
    localparam logic [2:0] PH_LENGTH  = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_CHECK   = 3'd5;
    localparam logic [2:0] PH_DONE    = 3'd6;

    logic [2:0]         phase_reg, phase_next;
    logic [LEN_W-1:0]   pos_reg, pos_next;
    logic [TYPE_W-1:0]  type_reg, type_next;
    logic [IDENT_W-1:0] ident_reg, ident_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [CHK_W-1:0]   chk_reg, chk_next;
    logic [CHK_W-1:0]   sum_reg, sum_next;    // payload sum, kept reduced mod 666
    logic               ended_reg, ended_next;

    // state as seen by this beat (a start flag clears the frame first)
    logic [2:0]         cur_phase;
    logic [LEN_W-1:0]   cur_pos;
    logic [TYPE_W-1:0]  cur_type;
    logic [IDENT_W-1:0] cur_ident;
    logic [LEN_W-1:0]   cur_len;
    logic [CHK_W-1:0]   cur_chk;
    logic [CHK_W-1:0]   cur_sum;
    logic               cur_ended;

    logic               is_digit;
    logic               digit_ok;
    logic [IDENT_W-1:0] acc_src;
    logic [IDENT_W-1:0] acc_new;
    logic [IDENT_W-1:0] val_next;
    logic [LEN_W-1:0]   pos_inc;
    logic [LEN_W-1:0]   field_n;
    logic               field_full;
    logic [CHK_W:0]     sum_add;
    logic [CHK_W-1:0]   sum_wrap;
    logic               pay_last;
    logic               type_ok;

    always_comb
    begin
        cur_phase = frame_start ? PH_TYPE : phase_reg;
        cur_pos   = frame_start ? '0 : pos_reg;
        cur_type  = frame_start ? '0 : type_reg;
        cur_ident = frame_start ? '0 : ident_reg;
        cur_len   = frame_start ? '0 : len_reg;
        cur_chk   = frame_start ? '0 : chk_reg;
        cur_sum   = frame_start ? '0 : sum_reg;
        cur_ended = frame_start ? 1'b0 : ended_reg;

        is_digit = byte_in inside {[8'h30:8'h39]};
        digit_ok = is_digit && !cur_ended;

        case (cur_phase)
            PH_TYPE:   acc_src = {{(IDENT_W-TYPE_W){1'b0}}, cur_type};
            PH_IDENT:  acc_src = cur_ident;
            PH_LENGTH: acc_src = {{(IDENT_W-LEN_W){1'b0}}, cur_len};
            PH_CHECK:  acc_src = {{(IDENT_W-CHK_W){1'b0}}, cur_chk};
            default:   acc_src = '0;
        endcase

        // x*10 + digit; the low nibble of an ASCII digit is its value
        acc_new  = (acc_src << 3) + (acc_src << 1)
                 + {{(IDENT_W-4){1'b0}}, byte_in[3:0]};
        val_next = digit_ok ? acc_new : acc_src;

        case (cur_phase)
            PH_TYPE:   field_n = LEN_W'(TYPE_DIGITS);
            PH_IDENT:  field_n = LEN_W'(IDENT_DIGITS);
            PH_LENGTH: field_n = LEN_W'(LENGTH_DIGITS);
            PH_CHECK:  field_n = LEN_W'(CHECK_DIGITS);
            default:   field_n = '0;
        endcase

        pos_inc    = cur_pos + LEN_W'(1);
        field_full = pos_inc >= field_n;
        pay_last   = pos_inc >= cur_len;

        // sum < 666 and byte <= 255, so one conditional subtract keeps it reduced
        sum_add  = {1'b0, cur_sum} + {{(CHK_W-7){1'b0}}, byte_in};
        sum_wrap = (sum_add >= (CHK_W+1)'(CHECK_MODULUS))
                 ? CHK_W'(sum_add - (CHK_W+1)'(CHECK_MODULUS))
                 : sum_add[CHK_W-1:0];

        type_ok = cur_type inside {[4'd1:4'd6]};

        phase_next = cur_phase;
        pos_next   = cur_pos;
        type_next  = cur_type;
        ident_next = cur_ident;
        len_next   = cur_len;
        chk_next   = cur_chk;
        sum_next   = cur_sum;
        ended_next = cur_ended;
        res_vld    = 1'b0;
        res        = '0;

        // shared counting for the decimal fields
        if (cur_phase == PH_TYPE || cur_phase == PH_IDENT ||
            cur_phase == PH_LENGTH || cur_phase == PH_CHECK)
        begin
            if (field_full)
            begin
                pos_next   = '0;
                ended_next = 1'b0;
            end
            else
            begin
                pos_next   = pos_inc;
                ended_next = !digit_ok;
            end
        end

        case (cur_phase)
            PH_TYPE:
            begin
                type_next = val_next[TYPE_W-1:0];
                if (field_full)
                begin
                    phase_next = PH_IDENT;
                end
            end
            PH_IDENT:
            begin
                ident_next = val_next;
                if (field_full)
                begin
                    phase_next = PH_LENGTH;
                end
            end
            PH_LENGTH:
            begin
                len_next = val_next[LEN_W-1:0];
                if (field_full)
                begin
                    phase_next = (val_next[LEN_W-1:0] == '0) ? PH_CHECK : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                sum_next = sum_wrap;
                if (pay_last)
                begin
                    pos_next   = '0;
                    ended_next = 1'b0;
                    phase_next = PH_CHECK;
                end
                else
                begin
                    pos_next = pos_inc;
                end
                res_vld              = 1'b1;
                res.result_kind      = KIND_PAYLOAD;
                res.payload_byte     = byte_in;
                res.payload_last     = pay_last;
            end
            PH_CHECK:
            begin
                chk_next = val_next[CHK_W-1:0];
                if (field_full)
                begin
                    phase_next         = PH_DONE;
                    res_vld            = 1'b1;
                    res.result_kind    = KIND_SUMMARY;
                    res.message_type   = cur_type;
                    res.message_ident  = cur_ident;
                    res.payload_length = cur_len;
                    res.received_check = val_next[CHK_W-1:0];
                    res.computed_check = cur_sum;
                    res.verdict        = (type_ok && val_next[CHK_W-1:0] == cur_sum)
                                       ? cur_type[VERD_W-1:0] : '0;
                end
            end
            default:
            begin
                // idle or frame done: bytes are dropped until the next start
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            type_reg  <= '0;
            ident_reg <= '0;
            len_reg   <= '0;
            chk_reg   <= '0;
            sum_reg   <= '0;
            ended_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            type_reg  <= type_next;
            ident_reg <= ident_next;
            len_reg   <= len_next;
            chk_reg   <= chk_next;
            sum_reg   <= sum_next;
            ended_reg <= ended_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/ascii_frame_deframer_checksum_core.sv =====
// ----------------------------------------------------------------------------
// ascii_frame_deframer_checksum_core
// Byte-stream deframer for ASCII frames: passes payload bytes through and
// emits a checked summary beat after the checksum digits.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                          | tuser        | tlast
//  s_*     | in  | byte_in[7:0]                   | frame_start  | -
//  m_*     | out | payload byte, summary fields   | result_kind  | payload_last
//
//  One beat per clock sustained while m_tready holds high; a result beat is
//  formed by the input register, then parse logic into the output register.
//  A beat that yields no result still passes through the parse step.
//  rst_n clears the handshake state and the parser to idle, waiting for start.
//  m_tready low holds the output register; the input register keeps taking
//  a beat while the parse step can still move.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_frame_deframer_checksum_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] byte_in
    input  wire logic        s_tuser,   // [0] frame_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [7:0] payload_byte, [11:8] message_type,
                                        // [28:12] message_ident, [38:29] payload_length,
                                        // [48:39] received_check, [58:49] computed_check,
                                        // [61:59] verdict, [63:62] zero
    output logic             m_tuser,   // [0] result_kind
    output logic             m_tlast    // payload_last
);
    import afd_pkg::*;

    logic        in_vld_reg, in_vld_next;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;
    logic        out_vld_reg, out_vld_next;
    afd_result_t out_res_reg;

    logic        step;
    logic        res_vld;
    afd_result_t res;

    assign step     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || step;

    afd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .byte_in     (in_byte_reg),
        .frame_start (in_start_reg),
        .res_vld     (res_vld),
        .res         (res)
    );

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (s_tready)
        begin
            in_vld_next = s_tvalid;
        end

        out_vld_next = out_vld_reg;
        if (step)
        begin
            out_vld_next = res_vld;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (step && res_vld)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_res_reg.result_kind;
    assign m_tlast  = out_res_reg.payload_last;
    assign m_tdata  = {2'b00,
                       out_res_reg.verdict,
                       out_res_reg.computed_check,
                       out_res_reg.received_check,
                       out_res_reg.payload_length,
                       out_res_reg.message_ident,
                       out_res_reg.message_type,
                       out_res_reg.payload_byte};

endmodule

`default_nettype wire

// ===== design/afd_checker.sv =====
// ----------------------------------------------------------------------------
// afd_checker
// Port-level checks on the deframer result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ascii_frame_deframer_checksum_core_assert.svh"

module afd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    `AFD_ASSERT_NEXT(a_out_valid_held, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")

    `AFD_ASSERT_NEXT(a_out_data_held, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result beat changed while stalled")

    // payload beats carry nothing but the byte; summary beats carry no byte
    `AFD_ASSERT_NOW(a_kind_fields, m_tvalid, (m_tuser ? (m_tdata[7:0] == 8'd0 && !m_tlast) : (m_tdata[63:8] == 56'd0)), "fields of the other result kind not zero")

    // a nonzero verdict means a matching checksum, a 1..6 type, and a reduced sum
    `AFD_ASSERT_NOW(a_verdict, m_tvalid && m_tuser && m_tdata[61:59] != 3'd0, m_tdata[48:39] == m_tdata[58:49] && m_tdata[61:59] == m_tdata[11:8] && m_tdata[11:8] <= 4'd6 && m_tdata[58:49] < 10'd666, "verdict inconsistent with checksum fields")

endmodule

bind ascii_frame_deframer_checksum_core afd_checker u_afd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/afd_frame_checker.sv =====
// ----------------------------------------------------------------------------
// afd_frame_checker
// Watches both stream channels of the ASCII frame deframer, parses each
// accepted input beat with its own copy of the parser state, queues the
// payload and summary beats it expects, and compares every output beat
// field by field against the oldest queued one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afd_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          errors,
    output int          pending
);
    import afd_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TYPE,
        PH_IDENT,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_CHECK,
        PH_DONE
    } parse_phase_t;

    parse_phase_t        phase;
    logic [9:0]          pos;
    logic [TYPE_W-1:0]   type_val;
    logic [IDENT_W-1:0]  ident_val;
    logic [LEN_W-1:0]    len_val;
    logic [CHK_W-1:0]    chk_val;
    logic [17:0]         byte_sum;
    logic                digits_ended;

    afd_result_t         frame_results_q[$];

    // digit accepted into the current field; a non-digit freezes the field
    function automatic bit digit_taken(logic [7:0] b);
        if (!digits_ended && b >= 8'h30 && b <= 8'h39)
            return 1'b1;
        digits_ended = 1'b1;
        return 1'b0;
    endfunction

    // low bits of v*10 + digit; truncation at the caller gives the field width
    function automatic logic [16:0] shift_digit(logic [16:0] v, logic [7:0] b);
        return 17'(v * 17'd10 + 17'(b - 8'h30));
    endfunction

    function automatic bit field_full(int unsigned n);
        pos = pos + 10'd1;
        if (pos >= n)
        begin
            pos          = '0;
            digits_ended = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic clear_frame();
        pos          = '0;
        type_val     = '0;
        ident_val    = '0;
        len_val      = '0;
        chk_val      = '0;
        byte_sum     = '0;
        digits_ended = 1'b0;
    endtask

    task automatic parse_beat(input logic [7:0] b, input logic start);
        afd_result_t r;
        logic [CHK_W-1:0] computed;
        r = '0;
        if (start)
        begin
            clear_frame();
            phase = PH_TYPE;
        end
        case (phase)
            PH_TYPE:
            begin
                if (digit_taken(b))
                    type_val = TYPE_W'(shift_digit(17'(type_val), b));
                if (field_full(TYPE_DIGITS))
                    phase = PH_IDENT;
            end
            PH_IDENT:
            begin
                if (digit_taken(b))
                    ident_val = shift_digit(ident_val, b);
                if (field_full(IDENT_DIGITS))
                    phase = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                if (digit_taken(b))
                    len_val = LEN_W'(shift_digit(17'(len_val), b));
                if (field_full(LENGTH_DIGITS))
                    phase = (len_val == '0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                byte_sum = byte_sum + 18'(b);
                pos      = pos + 10'd1;
                r.result_kind  = KIND_PAYLOAD;
                r.payload_byte = b;
                r.payload_last = (pos >= len_val);
                if (r.payload_last)
                begin
                    pos          = '0;
                    digits_ended = 1'b0;
                    phase        = PH_CHECK;
                end
                frame_results_q.push_back(r);
            end
            PH_CHECK:
            begin
                if (digit_taken(b))
                    chk_val = CHK_W'(shift_digit(17'(chk_val), b));
                if (field_full(CHECK_DIGITS))
                begin
                    phase    = PH_DONE;
                    computed = CHK_W'(byte_sum % CHECK_MODULUS);
                    r.result_kind    = KIND_SUMMARY;
                    r.message_type   = type_val;
                    r.message_ident  = ident_val;
                    r.payload_length = len_val;
                    r.received_check = chk_val;
                    r.computed_check = computed;
                    if (type_val >= 1 && type_val <= 6 && chk_val == computed)
                        r.verdict = VERD_W'(type_val);
                    frame_results_q.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    function automatic void check_field(string name, int unsigned exp_val,
                                        int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        afd_result_t want;
        if (!rst_n)
        begin
            phase  = PH_IDLE;
            errors = 0;
            clear_frame();
            frame_results_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (frame_results_q.size() == 0)
                begin
                    $error("output beat with nothing expected: tuser %0b tdata %h",
                           m_tuser, m_tdata);
                    errors++;
                end
                else
                begin
                    want = frame_results_q.pop_front();
                    check_field("result_kind",    want.result_kind,    m_tuser);
                    check_field("payload_byte",   want.payload_byte,   m_tdata[7:0]);
                    check_field("payload_last",   want.payload_last,   m_tlast);
                    check_field("message_type",   want.message_type,   m_tdata[11:8]);
                    check_field("message_ident",  want.message_ident,  m_tdata[28:12]);
                    check_field("payload_length", want.payload_length, m_tdata[38:29]);
                    check_field("received_check", want.received_check, m_tdata[48:39]);
                    check_field("computed_check", want.computed_check, m_tdata[58:49]);
                    check_field("verdict",        want.verdict,        m_tdata[61:59]);
                end
            end
            // results trail their input through the input and output registers, so order here is safe
            if (s_tvalid && s_tready)
                parse_beat(s_tdata, s_tuser);
        end
        pending = frame_results_q.size();
    end

endmodule

// ===== tb/ascii_frame_deframer_checksum_core_tb.sv =====
// ----------------------------------------------------------------------------
// ascii_frame_deframer_checksum_core_tb
// Feeds the deframer directed frames (extreme fields, zero length, bad type,
// bad checksum, non-digits, padding, aborted frames) and then random frames,
// with random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ascii_frame_deframer_checksum_core_tb;
    import afd_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_BEATS = 300;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [7:0] data;
        logic       start;
    } stream_byte_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int fail_count;
    int pending;

    bit tx_gaps  = 1'b1;
    bit rx_gaps  = 1'b1;
    bit hold_req = 1'b0;
    int beats_sent = 0;
    int idle_cycles = 0;

    stream_byte_t datagram_q[$];

    always #10 clk = ~clk;

    ascii_frame_deframer_checksum_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    afd_frame_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .errors   (fail_count),
        .pending  (pending)
    );

    task automatic push_byte(input logic [7:0] data, input logic start);
        stream_byte_t sb;
        sb.data  = data;
        sb.start = start;
        datagram_q.push_back(sb);
    endtask

    task automatic push_number(input int value, input int digits);
        int k;
        for (k = digits - 1; k >= 0; k--)
            push_byte(8'(8'h30 + (value / (10 ** k)) % 10), 1'b0);
    endtask

    // fill < 0 gives random payload bytes
    task automatic push_frame(input int type_digit, input int ident, input int len,
                              input int fill, input bit good_check);
        int sum;
        int i;
        logic [7:0] b;
        sum = 0;
        push_byte(8'(8'h30 + type_digit), 1'b1);
        push_number(ident, IDENT_DIGITS);
        push_number(len, LENGTH_DIGITS);
        for (i = 0; i < len; i++)
        begin
            b = (fill < 0) ? 8'($urandom) : 8'(fill);
            sum += b;
            push_byte(b, 1'b0);
        end
        push_number(good_check ? sum % CHECK_MODULUS : $urandom_range(0, 999),
                    CHECK_DIGITS);
    endtask

    function automatic logic [7:0] non_digit();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b >= 8'h30 && b <= 8'h39);
        return b;
    endfunction

    // entered and left at a falling edge
    task automatic send_datagram();
        stream_byte_t sb;
        while (datagram_q.size() > 0)
        begin
            sb = datagram_q.pop_front();
            if (tx_gaps && $urandom_range(0, 99) < 24)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 2)) @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= sb.data;
            s_tuser  <= sb.start;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            beats_sent++;
            @(negedge clk);
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            m_tready <= !rx_gaps || ($urandom_range(0, 99) >= 24);
        end
    end

    // watchdog on cycles with no beat on either channel
    initial
    begin
        @(posedge rst_n);
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int n;
        int idx;
        int mode;
        int stop_at;
        int cut;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // bytes before any start flag are dropped
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h37, 1'b0);
        send_datagram();

        // zero length, largest id, good check
        push_frame(1, 99999, 0, 0, 1'b1);
        send_datagram();

        // type out of range with matching check, then padding
        push_frame(9, 0, 2, 8'hFF, 1'b1);
        push_byte(8'h20, 1'b0);
        push_byte(8'hFF, 1'b0);
        send_datagram();

        push_frame(0, 1, 1, 8'h80, 1'b1);
        push_frame(6, 54321, 3, 0, 1'b1);
        send_datagram();

        // non-digit inside the id
        push_frame(3, 12345, 2, -1, 1'b1);
        datagram_q[3].data = 8'h78;
        send_datagram();

        // leading non-digit in the length, just below the digit range
        push_frame(4, 777, 5, -1, 1'b1);
        datagram_q[6].data = 8'h2F;
        send_datagram();

        // non-digit in the checksum, just above the digit range
        push_frame(2, 100, 4, -1, 1'b1);
        datagram_q[datagram_q.size() - 2].data = 8'h3A;
        send_datagram();

        // frame abandoned mid-payload by the next start flag
        push_frame(5, 4242, 6, -1, 1'b1);
        repeat (5) void'(datagram_q.pop_back());
        push_frame(6, 31337, 1, 8'h01, 1'b0);
        send_datagram();

        // received checksum of all nines
        push_frame(2, 1, 2, 0, 1'b0);
        for (idx = 1; idx <= 3; idx++)
            datagram_q[datagram_q.size() - idx].data = 8'h39;
        send_datagram();

        // largest length, abandoned after four payload bytes
        push_frame(3, 0, 999, -1, 1'b1);
        repeat (998) void'(datagram_q.pop_back());
        // long payload, sum well past the modulus
        push_frame(1, 65535, 60, 8'hFF, 1'b1);
        send_datagram();

        stop_at = beats_sent + RANDOM_BEATS;
        n = 0;
        while (beats_sent < stop_at)
        begin
            if (n == 3)
            begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            if (n == 8)
            begin
                tx_gaps = 1'b1;
                rx_gaps = 1'b1;
            end
            if (n == 10)
                hold_req = 1'b1;

            mode = $urandom_range(0, 99);
            if (mode < 95)
            begin
                push_frame(($urandom_range(0, 3) == 0) ? $urandom_range(0, 9)
                                                       : $urandom_range(1, 6),
                           $urandom_range(0, 99999), $urandom_range(0, 12), -1,
                           $urandom_range(0, 4) != 0);
                if (mode >= 70 && mode < 85)
                begin
                    idx = $urandom_range(0, 1) ? $urandom_range(0, 8)
                                               : datagram_q.size() - 1 - $urandom_range(0, 2);
                    datagram_q[idx].data = non_digit();
                end
                else if (mode >= 85)
                begin
                    cut = $urandom_range(1, datagram_q.size() - 1);
                    repeat (cut) void'(datagram_q.pop_back());
                end
                repeat ($urandom_range(0, 3)) push_byte(8'($urandom), 1'b0);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    push_byte(8'($urandom), $urandom_range(0, 7) == 0);
            end
            send_datagram();
            n++;
        end

        s_tvalid <= 1'b0;
        rx_gaps = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
